// ----- rtl/vt4_pkg.sv -----
// Shared types and constants for the 4x4 vertex transform unit.
package vt4_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned COEF_W = 32;
	localparam int unsigned REG_W = 64;
	localparam int unsigned NUM_REGS = 8;
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned PROD_W = DATA_W + COEF_W;
	// Four products summed at full precision need two guard bits.
	localparam int unsigned ACC_W = PROD_W + 2;
	localparam int unsigned FRAC_BITS_DEF = 16;

	localparam logic [1:0] MODE_FULL = 2'd0;
	localparam logic [1:0] MODE_POINT = 2'd1;
	localparam logic [1:0] MODE_DIR = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ROW3_COLS23 = 3'd7;

	// Reset matrix is the identity in Q16.16, kept as fixed bit patterns.
	localparam logic [REG_W-1:0] RST_ROW0_COLS01 = 64'h0001_0000_0000_0000;
	localparam logic [REG_W-1:0] RST_ROW0_COLS23 = 64'h0000_0000_0000_0000;
	localparam logic [REG_W-1:0] RST_ROW1_COLS01 = 64'h0000_0000_0001_0000;
	localparam logic [REG_W-1:0] RST_ROW1_COLS23 = 64'h0000_0000_0000_0000;
	localparam logic [REG_W-1:0] RST_ROW2_COLS01 = 64'h0000_0000_0000_0000;
	localparam logic [REG_W-1:0] RST_ROW2_COLS23 = 64'h0001_0000_0000_0000;
	localparam logic [REG_W-1:0] RST_ROW3_COLS01 = 64'h0000_0000_0000_0000;
	localparam logic [REG_W-1:0] RST_ROW3_COLS23 = 64'h0000_0000_0001_0000;

	localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [1:0]               func;
		logic signed [DATA_W-1:0] x_in;
		logic signed [DATA_W-1:0] y_in;
		logic signed [DATA_W-1:0] z_in;
		logic signed [DATA_W-1:0] w_in;
		logic                     batch_last_in;
	} vtx_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] x_out;
		logic signed [DATA_W-1:0] y_out;
		logic signed [DATA_W-1:0] z_out;
		logic signed [DATA_W-1:0] w_out;
		logic                     batch_last_out;
		logic                     overflow;
	} vtx_out_t;

endpackage

// ----- rtl/vertex_transform_4x4_unit.sv -----
// Pipelined 4x4 matrix by vector transform of Q16.16 vertices.
//
//   channel | direction | handshake            | payload
//   vtx     | in        | vtx_valid/vtx_stall  | vtx (vt4_pkg::vtx_in_t)
//   res     | out       | res_valid/res_stall  | res (vt4_pkg::vtx_out_t)
//   cfg     | in        | cfg_we               | cfg_index, cfg_data
//
// One vertex enters per clock unless vtx_stall holds it off.
// The stages are operand select, sixteen 32x32 multiplies, pair sums, final sum,
// and shift with saturation; the multiply stage sets the clock period.
// Reset loads the identity matrix and empties the pipeline.
// Each stage holds only while it is full and the one after it is holding, so bubbles are
// squeezed out and vtx_stall rises only when all five stages are full.
module vertex_transform_4x4_unit #(
	parameter int unsigned FRAC_BITS = vt4_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                vtx_valid,
	output logic                                vtx_stall,
	input  vt4_pkg::vtx_in_t                    vtx,
	output logic                                res_valid,
	input  logic                                res_stall,
	output vt4_pkg::vtx_out_t                   res,
	input  logic                                cfg_we,
	input  logic [vt4_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [vt4_pkg::REG_W-1:0]           cfg_data
);

	localparam int unsigned DW = vt4_pkg::DATA_W;
	localparam int unsigned PW = vt4_pkg::PROD_W;
	localparam int unsigned AW = vt4_pkg::ACC_W;
	localparam int unsigned SH_W = AW - FRAC_BITS;
	localparam logic signed [DW-1:0] ONE_FIX = DW'(64'd1 << FRAC_BITS);

	logic [vt4_pkg::REG_W-1:0] mat_q [vt4_pkg::NUM_REGS];
	logic signed [vt4_pkg::COEF_W-1:0] coef [4][4];

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	logic signed [DW-1:0] op_s1 [4];
	logic full_s1, full_s2, full_s3, full_s4;
	logic last_s1, last_s2, last_s3, last_s4;
	logic signed [PW-1:0] prod_s2 [4][4];
	logic signed [PW:0] pair_s3 [4][2];
	logic signed [AW-1:0] sum_s4 [4];
	vt4_pkg::vtx_out_t res_s5;

	logic signed [DW-1:0] sat_val [4];
	logic of_row [4];

	// Matrix registers; rewrite only while the pipeline is empty (not enforced).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q[0] <= vt4_pkg::RST_ROW0_COLS01;
			mat_q[1] <= vt4_pkg::RST_ROW0_COLS23;
			mat_q[2] <= vt4_pkg::RST_ROW1_COLS01;
			mat_q[3] <= vt4_pkg::RST_ROW1_COLS23;
			mat_q[4] <= vt4_pkg::RST_ROW2_COLS01;
			mat_q[5] <= vt4_pkg::RST_ROW2_COLS23;
			mat_q[6] <= vt4_pkg::RST_ROW3_COLS01;
			mat_q[7] <= vt4_pkg::RST_ROW3_COLS23;
		end else if (cfg_we) begin
			mat_q[cfg_index] <= cfg_data;
		end
	end

	// Even columns sit in the upper half of each register.
	for (genvar r = 0; r < 4; r++) begin : g_row
		for (genvar c = 0; c < 4; c++) begin : g_col
			if (c % 2 == 0) begin : g_hi
				assign coef[r][c] = mat_q[r*2 + c/2][63:32];
			end else begin : g_lo
				assign coef[r][c] = mat_q[r*2 + c/2][31:0];
			end
		end
	end

	assign en5 = !v_s5 || !res_stall;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign vtx_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= vtx_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// The fourth operand folds the translation column in: w for the full
	// product, 1.0 for a point, zero for a direction.
	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1[0] <= vtx.x_in;
			op_s1[1] <= vtx.y_in;
			op_s1[2] <= vtx.z_in;
			case (vtx.func)
				vt4_pkg::MODE_FULL:  op_s1[3] <= vtx.w_in;
				vt4_pkg::MODE_POINT: op_s1[3] <= ONE_FIX;
				default:             op_s1[3] <= '0;
			endcase
			full_s1 <= (vtx.func == vt4_pkg::MODE_FULL);
			last_s1 <= vtx.batch_last_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					prod_s2[r][c] <= op_s1[c] * coef[r][c];
				end
			end
			full_s2 <= full_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			for (int r = 0; r < 4; r++) begin
				pair_s3[r][0] <= (PW+1)'(prod_s2[r][0]) + (PW+1)'(prod_s2[r][1]);
				pair_s3[r][1] <= (PW+1)'(prod_s2[r][2]) + (PW+1)'(prod_s2[r][3]);
			end
			full_s3 <= full_s2;
			last_s3 <= last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			for (int r = 0; r < 4; r++) begin
				sum_s4[r] <= AW'(pair_s3[r][0]) + AW'(pair_s3[r][1]);
			end
			full_s4 <= full_s3;
			last_s4 <= last_s3;
		end
	end

	// Dropping the fraction bits of a two's complement sum rounds toward
	// minus infinity; the sum saturates when bit 31 and the bits above it disagree.
	always_comb begin
		logic [SH_W-1:0] sh;
		logic [SH_W-DW:0] hi;
		for (int r = 0; r < 4; r++) begin
			sh = sum_s4[r][AW-1:FRAC_BITS];
			hi = sh[SH_W-1:DW-1];
			of_row[r] = !((&hi) || !(|hi));
			if (!of_row[r]) begin
				sat_val[r] = sh[DW-1:0];
			end else if (sh[SH_W-1]) begin
				sat_val[r] = vt4_pkg::SAT_MIN;
			end else begin
				sat_val[r] = vt4_pkg::SAT_MAX;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			res_s5.x_out <= sat_val[0];
			res_s5.y_out <= sat_val[1];
			res_s5.z_out <= sat_val[2];
			res_s5.w_out <= full_s4 ? sat_val[3] : '0;
			res_s5.batch_last_out <= last_s4;
			res_s5.overflow <= of_row[0] || of_row[1] || of_row[2] || (full_s4 && of_row[3]);
		end
	end

	assign res_valid = v_s5;
	assign res = res_s5;

endmodule

// ----- rtl/vt4_checker.sv -----
// Port-level checks for the vertex transform unit, bound to its top level.
module vt4_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              vtx_valid,
	input logic              vtx_stall,
	input vt4_pkg::vtx_in_t  vtx,
	input logic              res_valid,
	input logic              res_stall,
	input vt4_pkg::vtx_out_t res
);

	// A stalled input transfer keeps its place and its payload until it is taken.
	a_vtx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid && vtx_stall |=> vtx_valid && $stable(vtx))
		else $error("input payload changed or dropped while stalled");

	// A held result keeps its place and its value.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed or dropped while stalled");

	// The input side only backs up when a finished result is being held.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_stall |-> res_valid && res_stall)
		else $error("input stalled without a held result");

	// A saturated transfer carries at least one clamped component.
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.overflow |->
			res.x_out == vt4_pkg::SAT_MAX || res.x_out == vt4_pkg::SAT_MIN ||
			res.y_out == vt4_pkg::SAT_MAX || res.y_out == vt4_pkg::SAT_MIN ||
			res.z_out == vt4_pkg::SAT_MAX || res.z_out == vt4_pkg::SAT_MIN ||
			res.w_out == vt4_pkg::SAT_MAX || res.w_out == vt4_pkg::SAT_MIN)
		else $error("overflow flagged with no clamped component");

	// The stall never reaches the input while the output register is empty.
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !vtx_stall)
		else $error("input stalled with an empty output register");

endmodule

bind vertex_transform_4x4_unit vt4_checker u_vt4_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.vtx_valid (vtx_valid),
	.vtx_stall (vtx_stall),
	.vtx       (vtx),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
